@@ src/lru_key_value_cache_defines.svh @@
// Assertion helpers shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LKVC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int LKVC_MAX_ENTRIES = 16;
  localparam int KEY_W            = 32;
  localparam int VAL_W            = 32;
  localparam int CAP_W            = 5;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CAP_W-1:0]        cap_t;

  localparam cap_t   CAP_RESET  = cap_t'(16);
  localparam value_t MISS_VALUE = '1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

endpackage

@@ src/lkvc_ifs.sv @@
interface lkvc_req_if;
  import lkvc_pkg::*;
  logic   valid;
  logic   ready;
  logic   action;
  key_t   key;
  value_t value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  value_t read_value;
  logic   evicted;

  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

interface lkvc_cfg_if;
  import lkvc_pkg::*;
  logic valid;
  logic ready;
  cap_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ src/lkvc_ram.sv @@
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lru_key_value_cache.sv @@
// channel  dir  payload                      transfer when
// req      in   action, key, value           req.valid & req.ready
// rsp      out  hit, read_value, evicted     rsp.valid & rsp.ready
// cfg      in   data (capacity_limit)        cfg.valid & cfg.ready (ready always high)
//
// One access per cycle unless the response stalls: an item waits in the input
// register, where all keys are compared at once and the ranks adjusted, then moves
// to the result register.
// Stored values live in a RAM whose registered read port supplies read_value.
// A stalled response holds the input register; req.ready stays high while it has room.
// Synchronous reset empties the store; no clearing pass is needed.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkvc_pkg::LKVC_MAX_ENTRIES
) (
  input logic         clk,
  input logic         rst,
  lkvc_req_if.sink    req,
  lkvc_rsp_if.source  rsp,
  lkvc_cfg_if.sink    cfg
);
  import lkvc_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

  typedef logic [MAX_ENTRIES-1:0] vec_t;
  typedef logic [RANK_W-1:0]      rank_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [OCC_W-1:0]       occ_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MISS,
    SRC_RAM
  } rd_src_t;

  function automatic idx_t encode(input vec_t oh);
    idx_t r;
    r = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (oh[i]) begin
        r = r | idx_t'(i);
      end
    end
    return r;
  endfunction

  // configuration
  cap_t capacity_limit;

  // tag store
  vec_t  valid;
  key_t  keys [MAX_ENTRIES];
  rank_t rank [MAX_ENTRIES];
  occ_t  occupancy;

  // input register
  logic   s1_valid;
  logic   s1_action;
  key_t   s1_key;
  value_t s1_value;

  // result register
  logic    o_valid;
  logic    o_hit;
  logic    o_evicted;
  rd_src_t o_src;

  logic   advance;
  logic   is_set;
  vec_t   match;
  logic   hit_any;
  idx_t   hit_idx;
  rank_t  hit_rank;
  vec_t   victim;
  vec_t   free_oh;
  vec_t   slot_oh;
  idx_t   slot;
  rank_t  occ_last;
  rank_t  thresh;
  logic   full;
  logic   do_evict;
  logic   do_insert;
  logic   upd;
  logic [CMP_W-1:0] cap_eff;
  value_t ram_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity_limit <= cfg.data;
    end
  end

  assign advance   = s1_valid && (!o_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_action <= req.action;
      s1_key    <= req.key;
      s1_value  <= req.value;
    end
  end

  // lookup and replacement choice
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == s1_key);
    end
  end

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match[i]) begin
        hit_rank = hit_rank | rank[i];
      end
    end
  end

  // valid ranks always form 0..occupancy-1, so the LRU entry holds occupancy-1
  assign occ_last = rank_t'(occupancy - occ_t'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      victim[i] = valid[i] && (rank[i] == occ_last);
    end
  end

  always_comb begin
    if (capacity_limit == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity_limit) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(capacity_limit);
    end
  end

  assign is_set    = (s1_action == ACT_SET);
  assign hit_any   = |match;
  assign hit_idx   = encode(match);
  assign full      = CMP_W'(occupancy) >= cap_eff;
  assign do_evict  = is_set && !hit_any && full;
  assign do_insert = is_set && !hit_any && !full;
  assign upd       = hit_any || is_set;
  assign free_oh   = ~valid & (valid + vec_t'(1));
  assign slot_oh   = hit_any ? match : (do_evict ? victim : free_oh);
  assign slot      = encode(slot_oh);
  assign thresh    = hit_any ? hit_rank : occ_last;

  // rank adjust: slot goes to zero, entries more recent than it (all, on insert) age by one
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (advance && upd) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_oh[i]) begin
          rank[i] <= '0;
          if (do_insert) begin
            valid[i] <= 1'b1;
          end
        end else if (valid[i] && (do_insert || rank[i] < thresh)) begin
          rank[i] <= rank[i] + rank_t'(1);
        end
      end
      if (do_insert) begin
        occupancy <= occupancy + occ_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (do_evict || do_insert)) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_oh[i]) begin
          keys[i] <= s1_key;
        end
      end
    end
  end

  lkvc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_values (
    .clk   (clk),
    .we    (advance && is_set),
    .waddr (slot),
    .wdata (s1_value),
    .re    (advance && !is_set && hit_any),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_hit     <= hit_any;
      o_evicted <= do_evict;
      if (is_set) begin
        o_src <= SRC_ZERO;
      end else if (hit_any) begin
        o_src <= SRC_RAM;
      end else begin
        o_src <= SRC_MISS;
      end
    end
  end

  assign rsp.valid   = o_valid;
  assign rsp.hit     = o_hit;
  assign rsp.evicted = o_evicted;

  always_comb begin
    unique case (o_src)
      SRC_RAM:  rsp.read_value = ram_rdata;
      SRC_MISS: rsp.read_value = MISS_VALUE;
      SRC_ZERO: rsp.read_value = '0;
      default:  rsp.read_value = '0;
    endcase
  end

  `LKVC_ASSERT_NOW(a_occ_matches_valid, clk, rst, 1'b1,
    $countones(valid) == int'(occupancy), "occupancy differs from valid count")
  `LKVC_ASSERT_NOW(a_single_match, clk, rst, s1_valid, $onehot0(match),
    "key present in more than one entry")
  `LKVC_ASSERT_NOW(a_victim_found, clk, rst, s1_valid && do_evict, $onehot(victim),
    "eviction without a unique least recent entry")
  `LKVC_ASSERT_NEXT(a_evict_keeps_occ, clk, rst, advance && do_evict, $stable(occupancy),
    "eviction changed occupancy")

endmodule
